>>> sv/pbrd_pkg.sv
// Shared types and constants for the pulse beat rate detector.
// Used by the multiply-accumulate unit, the serial divider, the top level and the checker.
// No dependencies.
package pbrd_pkg;

    // Field widths
    localparam int SAMPLE_W   = 12;
    localparam int ACC_W      = 20;
    localparam int RATE_W     = 8;
    localparam int TICK_W     = 32;

    // Port widths
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 24;
    localparam int M_TUSER_W  = 2;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_ADDR_W-1:0] CFG_FAST_ALPHA       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOW_ALPHA       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RISE_THRESHOLD   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FINGER_LOW       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_FINGER_HIGH      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_REFRACTORY_TICKS = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT_TICKS    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_TICK_PERIOD_MS   = 3'd7;

    // Shared multiplier: a 9-bit weight times a 12-bit value
    localparam int MAC_A_W    = 9;
    localparam int MAC_B_W    = 12;
    localparam int MAC_RES_W  = MAC_A_W + MAC_B_W;
    localparam logic [MAC_A_W-1:0] ALPHA_ONE = 9'd256;

    // Beat interval in ms; only intervals below 2048 ticks can land in range
    localparam int NEAR_TICK_W = 11;
    localparam int MS_W        = 19;
    localparam logic [MS_W-1:0] MS_MIN = 19'd300;
    localparam logic [MS_W-1:0] MS_MAX = 19'd2000;

    // Serial divider
    localparam int DIV_NUM_W = 16;
    localparam int DIV_DEN_W = 11;
    localparam logic [DIV_NUM_W-1:0] MS_PER_MINUTE = 16'd60000;

    typedef struct packed {
        logic                 accumulate;
        logic [MAC_A_W-1:0]   a;
        logic [MAC_B_W-1:0]   b;
    } mac_op_t;

    typedef struct packed {
        logic                   start;
        logic [DIV_NUM_W-1:0]   dividend;
        logic [DIV_DEN_W-1:0]   divisor;
    } div_req_t;

endpackage

>>> sv/pbrd_mac.sv
// Shared multiply-accumulate unit of the pulse beat rate detector.
// One product per cycle, registered; optionally added to the previous result.
// Depends on pbrd_pkg.
module pbrd_mac (
    input  logic                        aclk,
    input  pbrd_pkg::mac_op_t           op,
    output logic [pbrd_pkg::MAC_RES_W-1:0] res
);
    import pbrd_pkg::*;

    logic [MAC_RES_W-1:0] res_reg;
    logic [MAC_RES_W-1:0] product;

    // One 9 x 12 product per cycle.
    assign product = MAC_RES_W'(op.a) * MAC_RES_W'(op.b);

    // Either start a new sum or add to the held one.
    always_ff @(posedge aclk) begin
        if (op.accumulate) begin
            res_reg <= res_reg + product;
        end else begin
            res_reg <= product;
        end
    end

    assign res = res_reg;

endmodule

>>> sv/pbrd_div.sv
// Bit-serial restoring divider of the pulse beat rate detector.
// One quotient bit per cycle; done pulses when the quotient is ready.
// Depends on pbrd_pkg.
module pbrd_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pbrd_pkg::div_req_t             req,
    output logic [pbrd_pkg::DIV_NUM_W-1:0] quotient,
    output logic                           done
);
    import pbrd_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_DEN_W:0]   trial;
    logic                 fits;
    logic [DIV_DEN_W:0]   trial_sub;

    // Bring down the next dividend bit and try the subtraction.
    assign trial     = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign fits      = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    // Control: start, count the steps, flag completion.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_NUM_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient shifts in where the dividend shifts out.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            den_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

>>> sv/pulse_beat_rate_detector.sv
// Pulse beat rate detector: fast and slow IIR filters on a 12-bit pulse
// sensor stream, beat detection on their difference, and an averaged rate
// in beats per minute. One sample is taken at a time; s_tready stays low
// while it is worked on. A sample with no beat goes from acceptance to the
// result being loaded into the output register through the five passes
// through the shared multiplier (two per filter and one for the beat
// interval), the clear check and the output load. A beat whose interval is
// formed but falls out of range also passes the interval check. A beat with
// an interval in range adds the two 16-step divisions (60000 / interval and
// sum / count) in the serial divider and one history entry per cycle for
// the sum. s_tready returns as the result is loaded. A result that is not
// taken holds the next sample in the last state.
module pulse_beat_rate_detector #(
    parameter int HISTORY_DEPTH = 3
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Sample items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pbrd_pkg::S_TDATA_W-1:0]  s_tdata,   // [11:0] sample
    // Result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pbrd_pkg::M_TDATA_W-1:0]  m_tdata,   // [11:0] filtered,
                                                       // [19:12] beats_per_minute
    output logic [pbrd_pkg::M_TUSER_W-1:0]  m_tuser,   // [0] beat, [1] finger_present
    // Configuration writes
    input  logic                            cfg_we,
    input  logic [pbrd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [pbrd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import pbrd_pkg::*;

    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SUM_W = $clog2(HISTORY_DEPTH * 255 + 1);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HISTORY_DEPTH - 1);

    // Sequencer states
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [ST_W-1:0] ST_FAST_A   = 4'd1;
    localparam logic [ST_W-1:0] ST_FAST_B   = 4'd2;
    localparam logic [ST_W-1:0] ST_SLOW_A   = 4'd3;
    localparam logic [ST_W-1:0] ST_SLOW_B   = 4'd4;
    localparam logic [ST_W-1:0] ST_DETECT   = 4'd5;
    localparam logic [ST_W-1:0] ST_MS       = 4'd6;
    localparam logic [ST_W-1:0] ST_RATE_DIV = 4'd7;
    localparam logic [ST_W-1:0] ST_SUM      = 4'd8;
    localparam logic [ST_W-1:0] ST_MEAN_GO  = 4'd9;
    localparam logic [ST_W-1:0] ST_MEAN_DIV = 4'd10;
    localparam logic [ST_W-1:0] ST_CLEAR    = 4'd11;
    localparam logic [ST_W-1:0] ST_OUT      = 4'd12;

    // Configuration registers
    logic [7:0]  fast_alpha_reg;
    logic [7:0]  slow_alpha_reg;
    logic [11:0] rise_threshold_reg;
    logic [11:0] finger_low_reg;
    logic [11:0] finger_high_reg;
    logic [7:0]  refractory_ticks_reg;
    logic [9:0]  timeout_ticks_reg;
    logic [7:0]  tick_period_ms_reg;

    // Detector state
    logic [ST_W-1:0]     state_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [ACC_W-1:0]    fast_acc_reg;
    logic [ACC_W-1:0]    slow_acc_reg;
    logic [TICK_W-1:0]   tick_reg;
    logic [TICK_W-1:0]   last_beat_reg;
    logic                armed_reg;
    logic                finger_reg;
    logic                beat_reg;
    logic [RATE_W-1:0]   hist_reg [HISTORY_DEPTH];
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    ptr_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [RATE_W-1:0]   rate_reg;

    // Output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    // Shared units
    mac_op_t                mac_op;
    logic [MAC_RES_W-1:0]   mac_res;
    div_req_t               div_req;
    logic [DIV_NUM_W-1:0]   div_quo;
    logic                   div_done;

    // Detection terms
    logic [SAMPLE_W-1:0] fast_val;
    logic [SAMPLE_W-1:0] slow_val;
    logic signed [SAMPLE_W:0] delta;
    logic                finger;
    logic [TICK_W-1:0]   elapsed;
    logic                refractory;
    logic                rising;
    logic [MS_W-1:0]     ms;
    logic                ms_ok;
    logic                timed_out;

    pbrd_mac u_mac (
        .aclk (aclk),
        .op   (mac_op),
        .res  (mac_res)
    );

    pbrd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .quotient (div_quo),
        .done     (div_done)
    );

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_alpha_reg       <= 8'd128;
            slow_alpha_reg       <= 8'd4;
            rise_threshold_reg   <= 12'd40;
            finger_low_reg       <= 12'd1000;
            finger_high_reg      <= 12'd4090;
            refractory_ticks_reg <= 8'd12;
            timeout_ticks_reg    <= 10'd86;
            tick_period_ms_reg   <= 8'd35;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_FAST_ALPHA:       fast_alpha_reg       <= cfg_wdata[7:0];
                CFG_SLOW_ALPHA:       slow_alpha_reg       <= cfg_wdata[7:0];
                CFG_RISE_THRESHOLD:   rise_threshold_reg   <= cfg_wdata;
                CFG_FINGER_LOW:       finger_low_reg       <= cfg_wdata;
                CFG_FINGER_HIGH:      finger_high_reg      <= cfg_wdata;
                CFG_REFRACTORY_TICKS: refractory_ticks_reg <= cfg_wdata[7:0];
                CFG_TIMEOUT_TICKS:    timeout_ticks_reg    <= cfg_wdata[9:0];
                CFG_TICK_PERIOD_MS:   tick_period_ms_reg   <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // The fast value is final once SLOW_A has stored it; the slow value
    // comes straight from the multiplier in DETECT.
    assign fast_val   = fast_acc_reg[ACC_W-1:8];
    assign slow_val   = mac_res[ACC_W-1:8];
    assign delta      = $signed({1'b0, fast_val}) - $signed({1'b0, slow_val});
    assign finger     = (fast_val > finger_low_reg) && (fast_val < finger_high_reg);
    assign elapsed    = tick_reg - last_beat_reg;
    assign refractory = elapsed < TICK_W'(refractory_ticks_reg);
    assign rising     = finger && !refractory &&
                        (delta > $signed({1'b0, rise_threshold_reg}));
    assign ms         = mac_res[MS_W-1:0];
    assign ms_ok      = (ms > MS_MIN) && (ms < MS_MAX);
    assign timed_out  = elapsed > TICK_W'(timeout_ticks_reg);

    // Operand selection for the shared multiplier.
    always_comb begin
        mac_op = '0;
        case (state_reg)
            ST_FAST_A: begin
                mac_op.a = MAC_A_W'(fast_alpha_reg);
                mac_op.b = sample_reg;
            end
            ST_FAST_B: begin
                mac_op.accumulate = 1'b1;
                mac_op.a = ALPHA_ONE - MAC_A_W'(fast_alpha_reg);
                mac_op.b = fast_acc_reg[ACC_W-1:8];
            end
            ST_SLOW_A: begin
                mac_op.a = MAC_A_W'(slow_alpha_reg);
                mac_op.b = sample_reg;
            end
            ST_SLOW_B: begin
                mac_op.accumulate = 1'b1;
                mac_op.a = ALPHA_ONE - MAC_A_W'(slow_alpha_reg);
                mac_op.b = slow_acc_reg[ACC_W-1:8];
            end
            ST_DETECT: begin
                mac_op.a = MAC_A_W'(tick_period_ms_reg);
                mac_op.b = MAC_B_W'(elapsed[NEAR_TICK_W-1:0]);
            end
            default: ;
        endcase
    end

    // Divider requests: the rate from the beat interval, then the history mean.
    always_comb begin
        div_req = '0;
        case (state_reg)
            ST_MS: begin
                div_req.start    = ms_ok;
                div_req.dividend = MS_PER_MINUTE;
                div_req.divisor  = ms[DIV_DEN_W-1:0];
            end
            ST_MEAN_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_NUM_W'(sum_reg);
                div_req.divisor  = DIV_DEN_W'(cnt_reg);
            end
            default: ;
        endcase
    end

    // Sample register: loaded when an item is accepted.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sample_reg <= s_tdata[SAMPLE_W-1:0];
        end
    end

    // Sequencer and detector state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fast_acc_reg  <= '0;
            slow_acc_reg  <= '0;
            tick_reg      <= '0;
            last_beat_reg <= '0;
            armed_reg     <= 1'b0;
            finger_reg    <= 1'b0;
            beat_reg      <= 1'b0;
            idx_reg       <= '0;
            ptr_reg       <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            rate_reg      <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                hist_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        tick_reg  <= tick_reg + 1'b1;
                        beat_reg  <= 1'b0;
                        state_reg <= ST_FAST_A;
                    end
                end
                ST_FAST_A: state_reg <= ST_FAST_B;
                ST_FAST_B: state_reg <= ST_SLOW_A;
                ST_SLOW_A: begin
                    fast_acc_reg <= mac_res[ACC_W-1:0];
                    state_reg    <= ST_SLOW_B;
                end
                ST_SLOW_B: state_reg <= ST_DETECT;
                ST_DETECT: begin
                    slow_acc_reg <= mac_res[ACC_W-1:0];
                    finger_reg   <= finger;
                    state_reg    <= ST_CLEAR;
                    if (rising) begin
                        if (!armed_reg) begin
                            armed_reg     <= 1'b1;
                            beat_reg      <= 1'b1;
                            last_beat_reg <= tick_reg;
                            // Longer gaps cannot give an interval under 2000 ms.
                            if (elapsed[TICK_W-1:NEAR_TICK_W] == '0) begin
                                state_reg <= ST_MS;
                            end
                        end
                    end else if (delta < 0) begin
                        armed_reg <= 1'b0;
                    end
                end
                ST_MS: begin
                    state_reg <= ms_ok ? ST_RATE_DIV : ST_CLEAR;
                end
                ST_RATE_DIV: begin
                    if (div_done) begin
                        hist_reg[idx_reg] <= div_quo[RATE_W-1:0];
                        idx_reg   <= (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
                        ptr_reg   <= '0;
                        sum_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    // One history entry per cycle; empty entries do not count.
                    if (hist_reg[ptr_reg] != '0) begin
                        sum_reg <= sum_reg + SUM_W'(hist_reg[ptr_reg]);
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    ptr_reg <= ptr_reg + 1'b1;
                    if (ptr_reg == IDX_LAST) begin
                        state_reg <= ST_MEAN_GO;
                    end
                end
                ST_MEAN_GO: state_reg <= ST_MEAN_DIV;
                ST_MEAN_DIV: begin
                    if (div_done) begin
                        rate_reg  <= div_quo[RATE_W-1:0];
                        state_reg <= ST_CLEAR;
                    end
                end
                ST_CLEAR: begin
                    // No finger or no beat for too long: forget the rate.
                    if (timed_out || !finger_reg) begin
                        rate_reg <= '0;
                        idx_reg  <= '0;
                        for (int i = 0; i < HISTORY_DEPTH; i++) begin
                            hist_reg[i] <= '0;
                        end
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Output register: the result waits here until it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {{(M_TDATA_W - SAMPLE_W - RATE_W){1'b0}}, rate_reg, fast_val};
            m_tuser_reg <= {finger_reg, beat_reg};
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> sv/pbrd_checker.sv
// Port-level checks for the pulse beat rate detector, bound to its top level.
// Depends on pbrd_pkg and pulse_beat_rate_detector.
module pbrd_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [pbrd_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [pbrd_pkg::M_TUSER_W-1:0] m_tuser
);
    import pbrd_pkg::*;

    // A stalled result item keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // One sample at a time: the block is busy right after accepting an item.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while busy");

    // A beat is only reported with a finger present.
    a_beat_finger: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[1])
        else $error("beat reported without finger");

    // Without a finger the rate reads as unknown.
    a_rate_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> m_tdata[19:12] == '0)
        else $error("rate kept without finger");

endmodule

bind pulse_beat_rate_detector pbrd_checker u_pbrd_checker (.*);
